// File: rtl/core/srrip_pkg.sv
// Shared types and constants for the dueling RRIP replacement block.
package srrip_pkg;
    typedef logic [1:0] rrpv_t;
    typedef logic [1:0] sctr_t;
    typedef logic signed [2:0] score_t;

    localparam rrpv_t RRPV_MAX  = 2'd3;
    localparam rrpv_t RRPV_LONG = 2'd2;
    localparam rrpv_t RRPV_NEAR = 2'd0;
    localparam sctr_t DEAD_LIVE = 2'd2;
    localparam sctr_t DEAD_INIT = 2'd1;
    localparam sctr_t SCTR_INIT = 2'd1;
    localparam sctr_t SCTR_MAX  = 2'd3;
    localparam score_t SCORE_MAX = 3'sd3;
    localparam score_t SCORE_MIN = -3'sd4;
    localparam logic [63:0] STRIDE_POS = 64'd64;
    localparam logic [63:0] STRIDE_NEG = 64'hFFFF_FFFF_FFFF_FFC0;
    localparam logic [5:0] SET_HASH_MASK = 6'h3F;
    localparam logic [2:0] BYPASS_MASK = 3'h7;

    localparam logic CFG_STREAM_THR = 1'b0;
    localparam logic CFG_HOT_THR    = 1'b1;

    localparam logic MODE_VICTIM = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;
endpackage

// File: rtl/core/ship_rrip_dueling_replacement_top.sv
// Top level of the dueling RRIP replacement block: control, set memories and tables.
//
// Usage: requests enter on s_axis (mode, set, way, address, pc, hit). A victim
// query (mode 0) produces one response on m_axis naming the way to evict; an
// access update (mode 1) produces no response.
// Config port: cfg_we with cfg_index 0 writes stream_threshold, 1 hot_threshold.
// Each request reads its set row from the block and set memories, then
// computes and writes the row back; no new request is taken until it is done.
// The update that reaches DECAY_PERIOD first runs a decay sweep over all
// NUM_SETS rows of the block memory, reading and then writing each row, then
// re-reads its own set and completes.
// After reset, a clearing pass over all NUM_SETS rows initializes both set
// memories; s_axis_tready stays low until it ends.
// The victim response sits in an output register; while it is not taken the
// block holds off every new request.
module ship_rrip_dueling_replacement_top #(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int SIG_ENTRIES  = 64,
    parameter int LEADER_SETS  = 32,
    parameter int SELECT_WIDTH = 10,
    parameter int DECAY_PERIOD = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: mode[0], set_index[11:1], way[15:12], address[79:16], pc[143:80],
    // hit[144], zero pad to 152 bits
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: victim_way[3:0], zero pad to 8 bits
    output logic [7:0]   m_axis_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [2:0]   cfg_wdata
);
    import srrip_pkg::*;

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int SIG_W  = $clog2(SIG_ENTRIES);
    localparam int CNT_W  = $clog2(DECAY_PERIOD);
    localparam int LANE_W = 4 + SIG_W;
    localparam int ROW_W  = NUM_WAYS * LANE_W;
    localparam logic [SELECT_WIDTH-1:0] SEL_MID = {1'b1, {(SELECT_WIDTH-1){1'b0}}};
    localparam logic [SELECT_WIDTH-1:0] SEL_MAX = {SELECT_WIDTH{1'b1}};
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DECAY_PERIOD - 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DREAD = 3'd4;
    localparam logic [2:0] ST_DWRITE = 3'd5;
    localparam logic [2:0] ST_REREAD = 3'd6;

    // lane layout: rrpv[1:0], dead[3:2], sig above
    logic [2:0]  state_reg, state_next;
    logic [SET_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] ucnt_reg, ucnt_next;
    logic [SELECT_WIDTH-1:0] psel_reg, psel_next;
    score_t sthr_reg;
    sctr_t  hthr_reg;
    sctr_t  sctr_reg [SIG_ENTRIES];
    sctr_t  sc_old_reg, sc_sig_reg;
    logic   out_v_reg;
    logic [WAY_W-1:0] out_w_reg;

    logic        mode_q;
    logic [SET_W-1:0] set_q;
    logic [WAY_W-1:0] way_q;
    logic [63:0] addr_q, pc_q;
    logic        hit_q;

    logic             mem_rd, mem_wr;
    logic [SET_W-1:0] mem_raddr, mem_waddr;
    logic [ROW_W-1:0] row_rd, row_wr;

    logic [66:0] sset_mem [NUM_SETS];
    logic [66:0] sset_rd, sset_wr;
    logic        sset_wr_en;

    srrip_block_mem #(.SET_W(SET_W), .ROW_W(ROW_W)) u_blk (
        .clk(clk), .rd_en(mem_rd), .rd_addr(mem_raddr), .rd_data(row_rd),
        .wr_en(mem_wr), .wr_addr(mem_waddr), .wr_data(row_wr)
    );

    always_ff @(posedge clk)
    begin
        if (sset_wr_en)
        begin
            // clearing pass writes score 0, previous address 0
            sset_mem[mem_waddr] <= (state_reg == ST_INIT) ? 67'd0 : sset_wr;
        end
        if (mem_rd)
        begin
            sset_rd <= sset_mem[mem_raddr];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_v_reg;
    wire in_req = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = 8'(4'(out_w_reg));

    // compute
    logic [1:0] top;
    logic [WAY_W-1:0] best;
    logic [ROW_W-1:0] row_new, row_victim, row_decay;
    logic [63:0] diff;
    score_t score_old, score_new;
    logic [SIG_W-1:0] sig, old_sig;
    logic ship_lead, ds_lead, ship_pol, stream_path, hot;
    logic [LANE_W-1:0] lane;
    sctr_t dead_w, sc_old;

    always_comb
    begin
        top  = 2'd0;
        best = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (row_rd[w*LANE_W +: 2] > top)
            begin
                top  = row_rd[w*LANE_W +: 2];
                best = WAY_W'(w);
            end
        end
        row_victim = row_rd;
        row_decay  = row_rd;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_victim[w*LANE_W +: 2] = row_rd[w*LANE_W +: 2] + (RRPV_MAX - top);
            if (row_rd[w*LANE_W+2 +: 2] != 2'd0)
            begin
                row_decay[w*LANE_W+2 +: 2] = row_rd[w*LANE_W+2 +: 2] - 2'd1;
            end
        end
    end

    always_comb
    begin
        diff      = addr_q - sset_rd[63:0];
        score_old = score_t'(sset_rd[66:64]);
        score_new = score_old;
        if (diff == STRIDE_POS || diff == STRIDE_NEG)
        begin
            if (score_old < SCORE_MAX) score_new = score_old + 3'sd1;
        end
        else if (diff != 64'd0)
        begin
            if (score_old > SCORE_MIN) score_new = score_old - 3'sd1;
        end
        sset_wr = {score_new, addr_q};

        sig       = SIG_W'(pc_q[63:2] ^ 62'(set_q & SET_W'(SET_HASH_MASK)));
        lane      = row_rd[way_q*LANE_W +: LANE_W];
        old_sig   = lane[LANE_W-1:4];
        dead_w    = lane[3:2];
        sc_old    = sc_old_reg;
        ship_lead = 32'(set_q) < LEADER_SETS;
        ds_lead   = !ship_lead && 32'(set_q) < 2 * LEADER_SETS;
        ship_pol  = ship_lead ? 1'b1 : (ds_lead ? 1'b0 : (psel_reg < SEL_MID));
        stream_path = !ship_pol && ((score_new >= sthr_reg) || dead_w == 2'd0);
        hot = sc_sig_reg >= hthr_reg;
        if (old_sig == sig && sc_old != 2'd0)
        begin
            hot = (sc_old - 2'd1) >= hthr_reg;
        end

        if (hit_q)
        begin
            lane[1:0] = RRPV_NEAR;
            lane[3:2] = DEAD_LIVE;
        end
        else
        begin
            lane[LANE_W-1:4] = sig;
            if (stream_path)
            begin
                lane[1:0] = ((pc_q[2:0] ^ addr_q[2:0]) & BYPASS_MASK) != 3'd0
                            ? RRPV_MAX : RRPV_LONG;
            end
            else if (ship_pol && hot)
            begin
                lane[1:0] = RRPV_NEAR;
                lane[3:2] = DEAD_LIVE;
            end
            else
            begin
                lane[1:0] = RRPV_LONG;
                lane[3:2] = DEAD_INIT;
            end
        end
        row_new = row_rd;
        row_new[way_q*LANE_W +: LANE_W] = lane;
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        ucnt_next  = ucnt_reg;
        psel_next  = psel_reg;
        mem_rd     = 1'b0;
        mem_raddr  = set_q;
        mem_wr     = 1'b0;
        mem_waddr  = set_q;
        row_wr     = row_new;
        sset_wr_en = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                mem_wr    = 1'b1;
                sset_wr_en = 1'b1;
                mem_waddr = ptr_reg;
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    row_wr[w*LANE_W +: LANE_W] = {{SIG_W{1'b0}}, DEAD_INIT, RRPV_LONG};
                end
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == SET_W'(NUM_SETS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_req)
                begin
                    if (s_axis_tdata[0] == MODE_UPDATE && ucnt_reg == CNT_LAST)
                    begin
                        // decay goes ahead of this update; its set is read after
                        ptr_next   = '0;
                        state_next = ST_DREAD;
                    end
                    else
                    begin
                        mem_rd    = 1'b1;
                        mem_raddr = SET_W'(s_axis_tdata[11:1]);
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_wr = 1'b1;
                state_next = ST_IDLE;
                if (mode_q == MODE_VICTIM)
                begin
                    row_wr = row_victim;
                end
                else
                begin
                    sset_wr_en = 1'b1;
                    ucnt_next  = (ucnt_reg == CNT_LAST) ? '0 : ucnt_reg + 1'b1;
                    if (!hit_q && stream_path && ds_lead && psel_reg != SEL_MAX)
                        psel_next = psel_reg + 1'b1;
                    if (!hit_q && !stream_path && ship_pol && hot && ship_lead
                        && psel_reg != '0)
                        psel_next = psel_reg - 1'b1;
                end
            end
            ST_DREAD:
            begin
                mem_rd    = 1'b1;
                mem_raddr = ptr_reg;
                state_next = ST_DWRITE;
            end
            ST_DWRITE:
            begin
                mem_wr    = 1'b1;
                mem_waddr = ptr_reg;
                row_wr    = row_decay;
                ptr_next  = ptr_reg + 1'b1;
                state_next = (ptr_reg == SET_W'(NUM_SETS - 1)) ? ST_REREAD : ST_DREAD;
            end
            ST_REREAD:
            begin
                mem_rd     = 1'b1;
                state_next = ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ptr_reg   <= '0;
            ucnt_reg  <= '0;
            psel_reg  <= SEL_MID;
            sthr_reg  <= 3'sd2;
            hthr_reg  <= 2'd2;
            out_v_reg <= 1'b0;
            for (int i = 0; i < SIG_ENTRIES; i++) sctr_reg[i] <= SCTR_INIT;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            ucnt_reg  <= ucnt_next;
            psel_reg  <= psel_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_STREAM_THR) sthr_reg <= score_t'(cfg_wdata);
                else hthr_reg <= cfg_wdata[1:0];
            end
            if (m_axis_tvalid && m_axis_tready) out_v_reg <= 1'b0;
            if (state_reg == ST_WRITE && mode_q == MODE_VICTIM) out_v_reg <= 1'b1;
            if (state_reg == ST_WRITE && mode_q == MODE_UPDATE)
            begin
                if (hit_q)
                begin
                    if (sc_old != SCTR_MAX) sctr_reg[old_sig] <= sc_old + 2'd1;
                end
                else if (sc_old != 2'd0)
                begin
                    sctr_reg[old_sig] <= sc_old - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            mode_q <= s_axis_tdata[0];
            set_q  <= SET_W'(s_axis_tdata[11:1]);
            way_q  <= WAY_W'(s_axis_tdata[15:12]);
            addr_q <= s_axis_tdata[79:16];
            pc_q   <= s_axis_tdata[143:80];
            hit_q  <= s_axis_tdata[144];
        end
        // counter table read once the row is in
        if (state_reg == ST_READ)
        begin
            sc_old_reg <= sctr_reg[old_sig];
            sc_sig_reg <= sctr_reg[sig];
        end
        if (state_reg == ST_WRITE && mode_q == MODE_VICTIM)
        begin
            out_w_reg <= best;
        end
    end
endmodule

// File: rtl/core/srrip_block_mem.sv
// Per-set block state memory: re-reference, signature and dead counters per way.
module srrip_block_mem #(
    parameter int SET_W = 11,
    parameter int ROW_W = 160
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    output logic [ROW_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  logic [ROW_W-1:0] wr_data
);
    logic [ROW_W-1:0] mem [2**SET_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// File: rtl/core/srrip_checker.sv
// Port-level checker for the dueling RRIP replacement block, with its bind.
module srrip_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    // a response holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("response dropped or changed while stalled");
    // no new request while a response is pending
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while response pending");
    // a request occupies the block for at least the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back request accepted");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:4] == 4'd0)
        else $error("response padding not zero");
endmodule

bind ship_rrip_dueling_replacement_top srrip_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
